/* hdl/rgbwp_pkg.sv */
// Shared types and constants of the RGB565 to RGB888 word packer.
// No dependencies; used by every module of the block.
package rgbwp_pkg;

   // RGB565 channel masks
   localparam logic [15:0] MASK_RED   = 16'hF800;
   localparam logic [15:0] MASK_GREEN = 16'h07E0;
   localparam logic [15:0] MASK_BLUE  = 16'h001F;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PACK_MODE     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_ORDER = 1'd1;

   // Register values
   localparam logic MODE_PACKED = 1'b0;
   localparam logic MODE_WIDE   = 1'b1;
   localparam logic ORDER_RED_HIGH  = 1'b0;
   localparam logic ORDER_BLUE_HIGH = 1'b1;

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One pixel's worth of bus words: one or two words, last flag on the final one
   typedef struct packed {
      logic [15:0] word0;
      logic [15:0] word1;
      logic        two;
      logic        last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* hdl/rgbwp_front.sv */
// Front part: configuration registers, pixel widening and packing state.
// Turns each accepted pixel into a job for the queue. Depends on rgbwp_pkg.
module rgbwp_front
   import rgbwp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   input  logic [15:0]            req_pixel,
   input  logic                   req_run_end,
   input  queue_status_type       queue_status,
   output logic                   push,
   output job_type                push_job
);

   logic       pack_mode_ff, pack_mode_in;
   logic       channel_order_ff, channel_order_in;
   logic       odd_phase_ff, odd_phase_in;
   logic [7:0] held_byte_ff, held_byte_in;

   logic [15:0] red_masked, green_masked, blue_masked;
   logic [7:0]  red8, green8, blue8, hi_byte, mid_byte, lo_byte;

   assign push = req_valid && !queue_status.full;

   // Widen each channel by a left shift with zero fill
   assign red_masked   = req_pixel & MASK_RED;
   assign green_masked = req_pixel & MASK_GREEN;
   assign blue_masked  = req_pixel & MASK_BLUE;
   assign red8   = red_masked[15:8];
   assign green8 = green_masked[10:3];
   assign blue8  = {blue_masked[4:0], 3'b000};

   assign hi_byte  = (channel_order_ff == ORDER_BLUE_HIGH) ? blue8 : red8;
   assign mid_byte = green8;
   assign lo_byte  = (channel_order_ff == ORDER_BLUE_HIGH) ? red8 : blue8;

   always_comb begin
      pack_mode_in     = pack_mode_ff;
      channel_order_in = channel_order_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PACK_MODE:     pack_mode_in     = csr_write_data[0];
            CSR_CHANNEL_ORDER: channel_order_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      odd_phase_in = odd_phase_ff;
      held_byte_in = held_byte_ff;
      push_job     = '0;
      push_job.last = req_run_end;
      if (pack_mode_ff == MODE_WIDE) begin
         push_job.word0 = {mid_byte, lo_byte};
         push_job.word1 = {8'h00, hi_byte};
         push_job.two   = 1'b1;
         if (req_run_end) begin
            odd_phase_in = 1'b0;
         end
      end else if (!odd_phase_ff) begin
         // Even pixel: hold the low byte, flush it at once on a run end
         push_job.word0 = {hi_byte, mid_byte};
         push_job.word1 = {lo_byte, 8'h00};
         push_job.two   = req_run_end;
         held_byte_in   = lo_byte;
         odd_phase_in   = !req_run_end;
      end else begin
         push_job.word0 = {held_byte_ff, hi_byte};
         push_job.word1 = {mid_byte, lo_byte};
         push_job.two   = 1'b1;
         odd_phase_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_mode_ff     <= MODE_PACKED;
         channel_order_ff <= ORDER_RED_HIGH;
         odd_phase_ff     <= 1'b0;
         held_byte_ff     <= 8'h00;
      end else begin
         pack_mode_ff     <= pack_mode_in;
         channel_order_ff <= channel_order_in;
         if (push) begin
            odd_phase_ff <= odd_phase_in;
            held_byte_ff <= held_byte_in;
         end
      end
   end

endmodule

/* hdl/rgbwp_queue.sv */
// Short job queue between the front and back parts.
// Register-based, one push and one pop per cycle. Depends on rgbwp_pkg.
module rgbwp_queue
   import rgbwp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type queue_status
);

   job_type             queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      logic [QPTR_W-1:0] result;
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + QPTR_W'(1);
      end
      return result;
   endfunction

   assign queue_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head_job = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> !push)
      else $error("push into full queue");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      queue_status.empty |-> !pop)
      else $error("pop from empty queue");

   a_count_track : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count lost a push");
`endif

endmodule

/* hdl/rgbwp_back.sv */
// Back part: steps through the words of the head job, one word a cycle while
// a job waits and rsp_stall is low, into the result register. Depends on rgbwp_pkg.
module rgbwp_back
   import rgbwp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type queue_status,
   output logic             pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [15:0]      rsp_bus_word,
   output logic             rsp_word_last
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_bus_word_ff, rsp_bus_word_in;
   logic        rsp_word_last_ff, rsp_word_last_in;
   logic        second_ff, second_in;
   logic        load;
   logic        final_word;

   assign load       = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign final_word = second_ff || !head_job.two;
   assign pop        = load && final_word;

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_bus_word_in  = rsp_bus_word_ff;
      rsp_word_last_in = rsp_word_last_ff;
      second_in        = second_ff;
      if (load) begin
         rsp_valid_in     = 1'b1;
         rsp_bus_word_in  = second_ff ? head_job.word1 : head_job.word0;
         rsp_word_last_in = final_word && head_job.last;
         second_in        = !final_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
      rsp_bus_word_ff  <= rsp_bus_word_in;
      rsp_word_last_ff <= rsp_word_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bus_word  = rsp_bus_word_ff;
   assign rsp_word_last = rsp_word_last_ff;

`ifndef SYNTHESIS
   a_second_has_job : assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !queue_status.empty)
      else $error("second word pending without a job");
`endif

endmodule

/* hdl/rgb565_to_rgb888_word_packer.sv */
// Top level of the RGB565 to RGB888 word packer for a 16-bit display bus.
// Depends on rgbwp_pkg, rgbwp_front, rgbwp_queue and rgbwp_back.
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_stall  req_pixel[15:0], req_run_end
//   rsp_        out        rsp_valid/rsp_stall  rsp_bus_word[15:0], rsp_word_last
//   csr_        in         csr_write_enable     csr_index[0], csr_write_data[0]
//
// Each pixel gives one or two bus words; the output register moves one word
// a cycle while rsp_stall is low: one word for a packed even pixel that is not
// a run end, two words in all other cases.
// A two-entry job queue lets the front accept pixels while words drain.
// Reset is synchronous: clears the mode registers, packing state and queue.
// req_stall rises only while the queue is full; rsp_stall holds the word.
module rgb565_to_rgb888_word_packer
   import rgbwp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_pixel,
   input  logic                   req_run_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_bus_word,
   output logic                   rsp_word_last
);

   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type queue_status;

   // Stall the pixel side only when no queue slot is free
   assign req_stall = queue_status.full;

   // Front: widen channels, apply channel order, track the held byte
   rgbwp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_pixel        (req_pixel),
      .req_run_end      (req_run_end),
      .queue_status     (queue_status),
      .push             (push),
      .push_job         (push_job)
   );

   // Decouple front and back
   rgbwp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_job     (push_job),
      .pop          (pop),
      .head_job     (head_job),
      .queue_status (queue_status)
   );

   // Back: emit the job's words in order, flag the run's final word
   rgbwp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .queue_status  (queue_status),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_bus_word  (rsp_bus_word),
      .rsp_word_last (rsp_word_last)
   );

endmodule
